@@ rtl/aescbc_pkg.sv @@
// Shared types, constants and functions for the AES-256 CBC encryptor.
package aescbc_pkg;

  typedef struct packed {
    logic [63:0] data_high;
    logic [63:0] data_low;
    logic [4:0]  byte_count;
    logic        is_last;
  } in_item_t;

  typedef struct packed {
    logic [63:0] cipher_high;
    logic [63:0] cipher_low;
    logic        is_final;
  } out_item_t;

  localparam logic [2:0] REG_KEY0 = 3'd0;
  localparam logic [2:0] REG_KEY1 = 3'd1;
  localparam logic [2:0] REG_KEY2 = 3'd2;
  localparam logic [2:0] REG_KEY3 = 3'd3;
  localparam logic [2:0] REG_IVH  = 3'd4;
  localparam logic [2:0] REG_IVL  = 3'd5;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_KEYLOAD,
    ST_KEYEXP,
    ST_ROUND,
    ST_OUT
  } state_t;

  localparam logic [7:0] SBOX [256] = '{
    8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
    8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
    8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
    8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
    8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
    8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
    8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
    8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
    8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
    8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
    8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
    8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
    8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
    8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
    8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
    8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
  };

  function automatic logic [31:0] sub_word(input logic [31:0] w);
    sub_word = {SBOX[w[31:24]], SBOX[w[23:16]], SBOX[w[15:8]], SBOX[w[7:0]]};
  endfunction

  function automatic logic [7:0] xtime(input logic [7:0] a);
    xtime = {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
  endfunction

endpackage

@@ rtl/aescbc_round.sv @@
// One AES round: SubBytes, ShiftRows, optional MixColumns, AddRoundKey.
module aescbc_round (
  input  logic [127:0] state_in,
  input  logic [127:0] round_key,
  input  logic         last_round,
  output logic [127:0] state_out
);
  import aescbc_pkg::*;

  logic [7:0] s [16];
  logic [7:0] t [16];
  logic [7:0] m [16];
  logic [7:0] a0, a1, a2, a3;

  always_comb begin
    for (int i = 0; i < 16; i++) begin
      s[i] = SBOX[state_in[127 - 8*i -: 8]];
    end
    for (int c = 0; c < 4; c++) begin
      for (int r = 0; r < 4; r++) begin
        t[4*c + r] = s[4*((c + r) % 4) + r];
      end
    end
    for (int c = 0; c < 4; c++) begin
      a0 = t[4*c];
      a1 = t[4*c + 1];
      a2 = t[4*c + 2];
      a3 = t[4*c + 3];
      if (last_round) begin
        m[4*c] = a0; m[4*c + 1] = a1; m[4*c + 2] = a2; m[4*c + 3] = a3;
      end else begin
        m[4*c]     = xtime(a0) ^ xtime(a1) ^ a1 ^ a2 ^ a3;
        m[4*c + 1] = a0 ^ xtime(a1) ^ xtime(a2) ^ a2 ^ a3;
        m[4*c + 2] = a0 ^ a1 ^ xtime(a2) ^ xtime(a3) ^ a3;
        m[4*c + 3] = xtime(a0) ^ a0 ^ a1 ^ a2 ^ xtime(a3);
      end
    end
    for (int i = 0; i < 16; i++) begin
      state_out[127 - 8*i -: 8] = m[i] ^ round_key[127 - 8*i -: 8];
    end
  end
endmodule

@@ rtl/aes256_cbc_pkcs7_encryptor.sv @@
// Top level of the AES-256 CBC encryptor with PKCS#7 padding.
//  channel | direction | ports
//  in      | input     | in_valid, in_stall, in_item
//  out     | output    | out_valid, out_stall, out_item
//  cfg     | input     | cfg_we, cfg_index, cfg_data
// A block passes through the accept step, fifteen round steps (whitening
// plus fourteen rounds, one 128-bit round-key row read per cycle) and a
// hand-off step into the output register.
// A message's first item adds a key load step and 52 schedule words.
// A full final block adds a further pass through the rounds for the padding block.
// Reset is synchronous, active low. A stalled result holds only the output
// register; the engine waits in hand-off while the next result is ready.
module aes256_cbc_pkcs7_encryptor (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  aescbc_pkg::in_item_t   in_item,
  output logic                   out_valid,
  input  logic                   out_stall,
  output aescbc_pkg::out_item_t  out_item,
  input  logic                   cfg_we,
  input  logic [2:0]             cfg_index,
  input  logic [63:0]            cfg_data
);
  import aescbc_pkg::*;

  logic [63:0] key_r [4];
  logic [63:0] ivh_r, ivl_r;
  // round-key memory: one row holds four schedule words
  logic [127:0] rk_mem [15];
  logic [127:0] rk_rd_r;
  logic [3:0]   rk_raddr;

  state_t       st_r, st_nxt;
  logic         in_msg_r;
  logic [127:0] chain_r;
  logic [127:0] s_r;
  logic [3:0]   rnd_r;
  logic         pad_pend_r;
  logic         final_r;
  logic [127:0] res_r;
  logic         res_final_r;
  logic         out_v_r;
  logic         out_free;

  // key expansion window: last 8 words
  logic [31:0]  w_r [8];
  logic [5:0]   wi_r;
  logic [127:0] row_acc_r;
  logic [31:0]  t_w, new_w;
  logic [7:0]   rc;

  logic [127:0] rnd_out;
  logic [127:0] blk;
  logic         take;

  assign take      = in_valid && !in_stall;
  assign in_stall  = (st_r != ST_IDLE);
  assign out_valid = out_v_r;
  assign out_free  = !out_v_r || !out_stall;
  assign out_item  = '{cipher_high: res_r[127:64], cipher_low: res_r[63:0],
                       is_final: res_final_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_r[0] <= '0; key_r[1] <= '0; key_r[2] <= '0; key_r[3] <= '0;
      ivh_r <= '0; ivl_r <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_KEY0: key_r[0] <= cfg_data;
        REG_KEY1: key_r[1] <= cfg_data;
        REG_KEY2: key_r[2] <= cfg_data;
        REG_KEY3: key_r[3] <= cfg_data;
        REG_IVH:  ivh_r <= cfg_data;
        REG_IVL:  ivl_r <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    t_w = w_r[7];
    rc  = 8'h01 << (wi_r[5:3] - 3'd1);
    if (wi_r[2:0] == 3'd0) begin
      t_w = sub_word({w_r[7][23:0], w_r[7][31:24]}) ^ {rc, 24'h0};
    end else if (wi_r[2:0] == 3'd4) begin
      t_w = sub_word(w_r[7]);
    end
    new_w = w_r[0] ^ t_w;
  end

  // padded block
  always_comb begin
    logic [4:0] cnt;
    logic [7:0] pv;
    cnt = (in_item.byte_count > 5'd16) ? 5'd16 : in_item.byte_count;
    if (!in_item.is_last) cnt = 5'd16;
    pv = 8'(5'd16 - cnt);
    blk = {in_item.data_high, in_item.data_low};
    for (int i = 0; i < 16; i++) begin
      if (5'(i) >= cnt) blk[127 - 8*i -: 8] = pv;
    end
  end

  always_comb begin
    rk_raddr = 4'd0;
    if (st_r == ST_ROUND && rnd_r != 4'd14) rk_raddr = rnd_r + 4'd1;
  end

  always_ff @(posedge clk) begin
    rk_rd_r <= rk_mem[rk_raddr];
    if (st_r == ST_KEYLOAD) begin
      rk_mem[0] <= {key_r[0], key_r[1]};
      rk_mem[1] <= {key_r[2], key_r[3]};
    end else if (st_r == ST_KEYEXP && wi_r[1:0] == 2'd3) begin
      rk_mem[wi_r[5:2]] <= {row_acc_r[95:0], new_w};
    end
  end

  aescbc_round u_round (
    .state_in  (s_r),
    .round_key (rk_rd_r),
    .last_round(rnd_r == 4'd14),
    .state_out (rnd_out)
  );

  always_comb begin
    st_nxt = st_r;
    unique case (st_r)
      ST_IDLE:    if (take) st_nxt = in_msg_r ? ST_ROUND : ST_KEYLOAD;
      ST_KEYLOAD: st_nxt = ST_KEYEXP;
      ST_KEYEXP:  if (wi_r == 6'd59) st_nxt = ST_ROUND;
      ST_ROUND:   if (rnd_r == 4'd14) st_nxt = ST_OUT;
      ST_OUT:     if (out_free) st_nxt = pad_pend_r ? ST_ROUND : ST_IDLE;
      default:    st_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= ST_IDLE;
      in_msg_r <= 1'b0;
      pad_pend_r <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      st_r <= st_nxt;
      if (take) begin
        in_msg_r   <= !in_item.is_last;
        pad_pend_r <= in_item.is_last && in_item.byte_count >= 5'd16;
      end else if (st_r == ST_OUT && out_free && pad_pend_r) begin
        pad_pend_r <= 1'b0;
      end
      if (st_r == ST_OUT && out_free) begin
        out_v_r <= 1'b1;
      end else if (!out_stall) begin
        out_v_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    unique case (st_r)
      ST_IDLE: begin
        if (take) begin
          s_r     <= blk ^ (in_msg_r ? chain_r : {ivh_r, ivl_r});
          final_r <= in_item.is_last && in_item.byte_count < 5'd16;
          rnd_r   <= 4'd0;
        end
      end
      ST_KEYLOAD: begin
        for (int i = 0; i < 4; i++) begin
          w_r[2*i]     <= key_r[i][63:32];
          w_r[2*i + 1] <= key_r[i][31:0];
        end
        wi_r <= 6'd8;
      end
      ST_KEYEXP: begin
        for (int i = 0; i < 7; i++) w_r[i] <= w_r[i + 1];
        w_r[7]    <= new_w;
        row_acc_r <= {row_acc_r[95:0], new_w};
        wi_r      <= wi_r + 6'd1;
      end
      ST_ROUND: begin
        // round 0 whitening uses row 0 already fetched
        s_r   <= (rnd_r == 4'd0) ? (s_r ^ rk_rd_r) : rnd_out;
        if (rnd_r == 4'd14) begin
          chain_r <= rnd_out;
        end
        rnd_r <= rnd_r + 4'd1;
      end
      ST_OUT: begin
        if (out_free) begin
          res_r       <= chain_r;
          res_final_r <= final_r;
          if (pad_pend_r) begin
            s_r     <= {16{8'h10}} ^ chain_r;
            final_r <= 1'b1;
            rnd_r   <= 4'd0;
          end
        end
      end
      default: ;
    endcase
  end
endmodule
